FILE: rtl/cic_mesh_paint_readout_macros.svh
// ----------------------------------------------------------------------------
// cic_mesh_paint_readout assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef CIC_MESH_PAINT_READOUT_MACROS_SVH
`define CIC_MESH_PAINT_READOUT_MACROS_SVH

// same-cycle implication
`define CICMPR_ASSERT_IMP(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define CICMPR_ASSERT_NXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/cicmpr_pkg.sv
// ----------------------------------------------------------------------------
// cicmpr_pkg
// types, codes and helpers for the cloud-in-cell paint and readout block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cicmpr_pkg;

   // default mesh and local region sizes
   localparam int MESH_X_DEF  = 256;
   localparam int MESH_Y_DEF  = 256;
   localparam int MESH_Z_DEF  = 256;
   localparam int LOCAL_X_DEF = 64;
   localparam int LOCAL_Y_DEF = 64;
   localparam int LOCAL_Z_DEF = 256;

   // compare width for mesh index, region start and region size
   // (mesh and local sizes stay at or below 4096)
   localparam int CMP_W = 14;

   // register reset values
   localparam logic [31:0] INV_CELL_RESET = 32'h0100_0000;
   localparam logic [6:0]  SIZE_XY_RESET  = 7'd64;
   localparam logic [8:0]  SIZE_Z_RESET   = 9'd256;

   // 1.0 in Q16.16
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   // register indexes
   typedef enum logic [2:0] {
      CFG_INV_CELL_X,
      CFG_INV_CELL_Y,
      CFG_INV_CELL_Z,
      CFG_REGION_START_X,
      CFG_REGION_START_Y,
      CFG_REGION_SIZE_X,
      CFG_REGION_SIZE_Y,
      CFG_REGION_SIZE_Z
   } cfg_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCALE,
      ST_WRAP_A,
      ST_WRAP_B,
      ST_WRAP_C,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // request payload
   typedef struct packed {
      logic               mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] weight;
      logic [1:0]         diff_axis;
   } req_type;

   // response payload
   typedef struct packed {
      logic signed [31:0] value;
      logic [3:0]         corners_inside;
   } rsp_type;

   // clamp to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

FILE: rtl/cic_mesh_paint_readout.sv
// ----------------------------------------------------------------------------
// cic_mesh_paint_readout
// Cloud-in-cell paint and readout on a periodic 3-D mesh with a local grid
// memory. Each request is scaled into cell units, its cell index wrapped on
// the mesh, and its eight neighbor cells are walked through the grid memory
// one per cycle: paint adds weight times kernel into each cell inside the
// region, readout returns the saturated kernel-weighted sum. Requests are
// accepted in ST_IDLE, scaled in ST_SCALE, wrapped in ST_WRAP_A to ST_WRAP_C,
// walked in ST_RUN (one grid memory read per cycle, write-back on a separate
// port from the end of the corner pipeline) and drained in ST_DRAIN, which
// posts the response. After reset the grid is zeroed by a clearing pass over
// all LOCAL_X*LOCAL_Y*LOCAL_Z cells (1048576 at the defaults) during which no
// request is taken; register writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cic_mesh_paint_readout_macros.svh"

module cic_mesh_paint_readout
   import cicmpr_pkg::*;
#(
   parameter int MESH_X  = MESH_X_DEF,
   parameter int MESH_Y  = MESH_Y_DEF,
   parameter int MESH_Z  = MESH_Z_DEF,
   parameter int LOCAL_X = LOCAL_X_DEF,
   parameter int LOCAL_Y = LOCAL_Y_DEF,
   parameter int LOCAL_Z = LOCAL_Z_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // derived sizes
   localparam longint GRID  = longint'(LOCAL_X) * LOCAL_Y * LOCAL_Z;
   localparam int     AW    = (GRID > 1) ? $clog2(GRID) : 1;
   localparam int     MMAX  = (MESH_X > MESH_Y) ? ((MESH_X > MESH_Z) ? MESH_X : MESH_Z)
                                                : ((MESH_Y > MESH_Z) ? MESH_Y : MESH_Z);
   localparam int     IW    = $clog2(MMAX);
   localparam int     LXW   = (LOCAL_X > 1) ? $clog2(LOCAL_X) : 1;
   localparam int     LYW   = (LOCAL_Y > 1) ? $clog2(LOCAL_Y) : 1;
   localparam int     LZW   = (LOCAL_Z > 1) ? $clog2(LOCAL_Z) : 1;
   localparam int     LMW   = (LXW > LYW) ? ((LXW > LZW) ? LXW : LZW)
                                          : ((LYW > LZW) ? LYW : LZW);

   // configuration registers
   logic [31:0] inv_x_ff, inv_y_ff, inv_z_ff;
   logic [7:0]  start_x_ff, start_y_ff;
   logic [6:0]  size_x_ff, size_y_ff;
   logic [8:0]  size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff   <= INV_CELL_RESET;
         inv_y_ff   <= INV_CELL_RESET;
         inv_z_ff   <= INV_CELL_RESET;
         start_x_ff <= '0;
         start_y_ff <= '0;
         size_x_ff  <= SIZE_XY_RESET;
         size_y_ff  <= SIZE_XY_RESET;
         size_z_ff  <= SIZE_Z_RESET;
      end else if (csr_we) begin
         case (cfg_index_type'(csr_index))
            CFG_INV_CELL_X:     inv_x_ff   <= csr_wdata;
            CFG_INV_CELL_Y:     inv_y_ff   <= csr_wdata;
            CFG_INV_CELL_Z:     inv_z_ff   <= csr_wdata;
            CFG_REGION_START_X: start_x_ff <= csr_wdata[7:0];
            CFG_REGION_START_Y: start_y_ff <= csr_wdata[7:0];
            CFG_REGION_SIZE_X:  size_x_ff  <= csr_wdata[6:0];
            CFG_REGION_SIZE_Y:  size_y_ff  <= csr_wdata[6:0];
            CFG_REGION_SIZE_Z:  size_z_ff  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // sequencer
   state_type      state_ff, state_in;
   logic [2:0]     cnt_ff;
   logic [AW-1:0]  clr_ff;
   req_type        req_ff;
   logic           pipe_busy;
   logic           issue, clearing, finish;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == AW'(GRID - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_WRAP_A;
         ST_WRAP_A: state_in = ST_WRAP_B;
         ST_WRAP_B: state_in = ST_WRAP_C;
         ST_WRAP_C: state_in = ST_RUN;
         ST_RUN:    if (cnt_ff == 3'd7) state_in = ST_DRAIN;
         ST_DRAIN:  if (!pipe_busy && (!rsp_valid_ff || rsp_ready)) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      clearing  = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_CLEAR: clearing  = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_RUN:   issue     = 1'b1;
         ST_DRAIN: finish    = !pipe_busy && (!rsp_valid_ff || rsp_ready);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (issue) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
   end

   // per-axis views
   logic signed [31:0]   pos_a   [3];
   logic [31:0]          inv_a   [3];
   logic [CMP_W-1:0]     start_a [3];
   logic [CMP_W-1:0]     lim_a   [3];
   logic signed [24:0]   fac_t   [3];
   logic signed [24:0]   fac_d   [3];
   logic                 ok_w    [3][2];
   logic [LMW-1:0]       loc_w   [3][2];

   assign pos_a[0]   = req_ff.pos_x;
   assign pos_a[1]   = req_ff.pos_y;
   assign pos_a[2]   = req_ff.pos_z;
   assign inv_a[0]   = inv_x_ff;
   assign inv_a[1]   = inv_y_ff;
   assign inv_a[2]   = inv_z_ff;
   assign start_a[0] = CMP_W'(start_x_ff);
   assign start_a[1] = CMP_W'(start_y_ff);
   assign start_a[2] = '0;
   // effective region size is capped by the local storage
   assign lim_a[0] = (CMP_W'(size_x_ff) < CMP_W'(LOCAL_X)) ? CMP_W'(size_x_ff)
                                                            : CMP_W'(LOCAL_X);
   assign lim_a[1] = (CMP_W'(size_y_ff) < CMP_W'(LOCAL_Y)) ? CMP_W'(size_y_ff)
                                                            : CMP_W'(LOCAL_Y);
   assign lim_a[2] = (CMP_W'(size_z_ff) < CMP_W'(LOCAL_Z)) ? CMP_W'(size_z_ff)
                                                            : CMP_W'(LOCAL_Z);

   // scale and wrap lanes, one per axis; settle within the wrap states
   for (genvar d = 0; d < 3; d++) begin : g_axis
      localparam int     M     = (d == 0) ? MESH_X : ((d == 1) ? MESH_Y : MESH_Z);
      localparam longint OFF   = ((64'sd8388608 + M - 1) / M) * M;
      localparam longint RECIP = 64'sd33554432 / M;

      logic signed [63:0] prod_ff;
      logic [24:0]        v_ff, q_ff, qm_ff;
      logic signed [24:0] ft_ff, fd_ff;
      logic               ok0_ff, ok1_ff;
      logic [LMW-1:0]     loc0_ff, loc1_ff;
      logic [24:0]        v, r, rc;
      logic [15:0]        frac;
      logic signed [24:0] g;
      logic [IW-1:0]      i0, i1;
      logic [CMP_W-1:0]   e0, e1, d0, d1;

      // index offset into a non-negative range, fraction and factors
      always_comb begin
         v    = 25'({prod_ff[63], prod_ff[63:40]}) + 25'(OFF);
         frac = prod_ff[39:24];
         g    = $signed({1'b0, inv_a[d][31:8]});
         r    = v_ff - qm_ff;
         rc   = (r >= 25'(M)) ? (r - 25'(M)) : r;
         i0   = IW'(rc);
         i1   = (i0 == IW'(M - 1)) ? '0 : (i0 + 1'b1);
         e0   = CMP_W'(i0);
         e1   = CMP_W'(i1);
         d0   = e0 - start_a[d];
         d1   = e1 - start_a[d];
      end

      always_ff @(posedge clock) begin
         prod_ff <= pos_a[d] * $signed({1'b0, inv_a[d]});
         v_ff    <= v;
         q_ff    <= 25'((50'(v) * 50'(RECIP)) >> 25);
         qm_ff   <= 25'(q_ff * 25'(M));
         if (req_ff.diff_axis == 2'(d + 1)) begin
            fd_ff <= g;
            ft_ff <= -g;
         end else begin
            fd_ff <= $signed({9'd0, frac});
            ft_ff <= $signed(25'(ONE_Q16 - {1'b0, frac}));
         end
         ok0_ff  <= (e0 >= start_a[d]) && (d0 < lim_a[d]);
         ok1_ff  <= (e1 >= start_a[d]) && (d1 < lim_a[d]);
         loc0_ff <= LMW'(d0);
         loc1_ff <= LMW'(d1);
      end

      assign fac_t[d]    = ft_ff;
      assign fac_d[d]    = fd_ff;
      assign ok_w[d][0]  = ok0_ff;
      assign ok_w[d][1]  = ok1_ff;
      assign loc_w[d][0] = loc0_ff;
      assign loc_w[d][1] = loc1_ff;
   end

   // corner select and first kernel product
   logic               ca, cb, cz;
   logic signed [24:0] fa, fb, fc;
   logic               ok_c;
   logic [AW-1:0]      addr_c;
   logic signed [49:0] fxy;

   always_comb begin
      ca     = cnt_ff[2];
      cb     = cnt_ff[1];
      cz     = cnt_ff[0];
      fa     = ca ? fac_d[0] : fac_t[0];
      fb     = cb ? fac_d[1] : fac_t[1];
      fc     = cz ? fac_d[2] : fac_t[2];
      ok_c   = ok_w[0][ca] && ok_w[1][cb] && ok_w[2][cz];
      addr_c = AW'((AW'(loc_w[0][ca][LXW-1:0]) * AW'(LOCAL_Y)
                    + AW'(loc_w[1][cb][LYW-1:0])) * AW'(LOCAL_Z)
                   + AW'(loc_w[2][cz][LZW-1:0]));
      fxy    = fa * fb;
   end

   // corner pipeline
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               ok1_ff, ok2_ff, ok3_ff, ok4_ff;
   logic [AW-1:0]      a1_ff, a2_ff, a3_ff, a4_ff;
   logic signed [33:0] fxy1_ff;
   logic signed [24:0] fc1_ff;
   logic signed [42:0] k2_ff;
   logic signed [31:0] cell2_ff, cell3_ff, cell4_ff;
   logic signed [52:0] ph3_ff;
   logic signed [54:0] pl3_ff;
   logic signed [58:0] term4_ff;
   logic signed [31:0] rd_data_ff;
   logic signed [58:0] kp;
   logic signed [31:0] mult_op;
   logic signed [74:0] total;

   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;

   always_comb begin
      kp      = fxy1_ff * fc1_ff;
      mult_op = req_ff.mode ? cell2_ff : req_ff.weight;
      total   = (75'(ph3_ff) <<< 22) + 75'(pl3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff   <= ok_c;
      a1_ff    <= addr_c;
      fxy1_ff  <= fxy[49:16];
      fc1_ff   <= fc;
      ok2_ff   <= ok1_ff;
      a2_ff    <= a1_ff;
      k2_ff    <= kp[58:16];
      cell2_ff <= rd_data_ff;
      ok3_ff   <= ok2_ff;
      a3_ff    <= a2_ff;
      cell3_ff <= cell2_ff;
      ph3_ff   <= $signed(k2_ff[42:22]) * mult_op;
      pl3_ff   <= $signed({1'b0, k2_ff[21:0]}) * mult_op;
      ok4_ff   <= ok3_ff;
      a4_ff    <= a3_ff;
      cell4_ff <= cell3_ff;
      term4_ff <= total[74:16];
   end

   // grid memory: one read port, one write port
   logic signed [31:0] grid_mem [GRID];
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               hit4;

   assign hit4 = v4_ff && ok4_ff;

   always_comb begin
      if (clearing) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = hit4 && !req_ff.mode;
         wr_addr = a4_ff;
         wr_data = sat32(64'(cell4_ff) + 64'(term4_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) grid_mem[wr_addr] <= wr_data;
      rd_data_ff <= grid_mem[addr_c];
   end

   // readout sum and corner count
   logic signed [61:0] acc_ff;
   logic [3:0]         count_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRAP_C) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else if (hit4) begin
         acc_ff   <= acc_ff + 62'(term4_ff);
         count_ff <= count_ff + 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff.value          <= req_ff.mode ? sat32(64'(acc_ff)) : '0;
         rsp_data_ff.corners_inside <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `CICMPR_ASSERT_IMP(a_idle_empty, req_ready, !pipe_busy, "request taken with corners in flight")
   `CICMPR_ASSERT_IMP(a_write_src, wr_en && !clearing, hit4 && !req_ff.mode,
                      "grid write outside a paint corner")
   `CICMPR_ASSERT_NXT(a_walk_end, issue && cnt_ff == 3'd7, state_ff == ST_DRAIN && v1_ff,
                      "corner walk did not end after eight corners")
   `CICMPR_ASSERT_IMP(a_count_max, rsp_valid, rsp_data.corners_inside <= 4'd8,
                      "corner count above eight")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench for cic_mesh_paint_readout
// Drives paint and readout requests through the valid/ready channels, keeps
// its own cloud-in-cell predictor with a sparse copy of the grid, and checks
// every response field by field. Covers directed corner cases, a sweep of
// register settings and random traffic under changing idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import cicmpr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CELLS_YZ       = LOCAL_Y_DEF * LOCAL_Z_DEF;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // predictor copy of the registers and the grid
   logic [31:0] inv_size [3];
   logic [7:0]  start_x, start_y;
   logic [6:0]  size_x, size_y;
   logic [8:0]  size_z;
   int          grid_cells [int];

   rsp_type     expected_rsp [$];
   int          mismatches;
   int          send_idle_pct;
   int          rsp_idle_pct;
   int          hold_left;
   int          quiet_cycles;

   cic_mesh_paint_readout DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // cloud-in-cell step: updates the grid copy on paint, returns the response
   function automatic rsp_type cic_step(input req_type r);
      longint  fac [3][2];
      longint  loc [3][2];
      bit      ok [3][2];
      longint  lim [3];
      longint  mesh [3];
      longint  pos, prod, idx, k, sum, cell_val, gain;
      int      addr;
      int      count;
      rsp_type res;
      mesh[0] = MESH_X_DEF;
      mesh[1] = MESH_Y_DEF;
      mesh[2] = MESH_Z_DEF;
      lim[0] = (size_x < LOCAL_X_DEF) ? size_x : LOCAL_X_DEF;
      lim[1] = (size_y < LOCAL_Y_DEF) ? size_y : LOCAL_Y_DEF;
      lim[2] = (size_z < LOCAL_Z_DEF) ? size_z : LOCAL_Z_DEF;
      sum = 0;
      count = 0;
      for (int d = 0; d < 3; d++) begin
         pos = (d == 0) ? longint'(r.pos_x) : (d == 1) ? longint'(r.pos_y)
                                                      : longint'(r.pos_z);
         prod = pos * longint'(inv_size[d]);
         idx = prod >>> 40;
         fac[d][1] = (prod >>> 24) & 64'hFFFF;
         fac[d][0] = 65536 - fac[d][1];
         if (r.diff_axis == d + 1) begin
            gain = longint'(inv_size[d] >> 8);
            fac[d][1] = gain;
            fac[d][0] = -gain;
         end
         // periodic wrap, then offset by region start (z region starts at 0)
         loc[d][0] = ((idx % mesh[d]) + mesh[d]) % mesh[d];
         loc[d][1] = (((idx + 1) % mesh[d]) + mesh[d]) % mesh[d];
         for (int j = 0; j < 2; j++) begin
            if (d == 0) loc[d][j] -= start_x;
            if (d == 1) loc[d][j] -= start_y;
            ok[d][j] = (loc[d][j] >= 0) && (loc[d][j] < lim[d]);
         end
      end
      for (int a = 0; a < 2; a++)
         for (int b = 0; b < 2; b++)
            for (int c = 0; c < 2; c++) begin
               if (ok[0][a] && ok[1][b] && ok[2][c]) begin
                  count++;
                  k = (((fac[0][a] * fac[1][b]) >>> 16) * fac[2][c]) >>> 16;
                  addr = int'(loc[0][a]) * CELLS_YZ + int'(loc[1][b]) * LOCAL_Z_DEF
                         + int'(loc[2][c]);
                  cell_val = grid_cells.exists(addr) ? longint'(grid_cells[addr]) : 0;
                  if (r.mode) begin
                     sum += (cell_val * k) >>> 16;
                  end else begin
                     grid_cells[addr] = int'(clamp32(cell_val +
                                        ((k * longint'(r.weight)) >>> 16)));
                  end
               end
            end
      res.value = r.mode ? 32'(clamp32(sum)) : 32'sd0;
      res.corners_inside = 4'(count);
      return res;
   endfunction

   // send one request, idling first at the current rate
   task automatic send_request(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(cic_step(r));
   endtask

   // wait until every expected response has come, plus the block's latency
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input cfg_index_type idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CFG_INV_CELL_X:     inv_size[0] = val;
         CFG_INV_CELL_Y:     inv_size[1] = val;
         CFG_INV_CELL_Z:     inv_size[2] = val;
         CFG_REGION_START_X: start_x = val[7:0];
         CFG_REGION_START_Y: start_y = val[7:0];
         CFG_REGION_SIZE_X:  size_x = val[6:0];
         CFG_REGION_SIZE_Y:  size_y = val[6:0];
         CFG_REGION_SIZE_Z:  size_z = val[8:0];
         default: ;
      endcase
   endtask

   task automatic set_region(input logic [31:0] ix, iy, iz, input logic [7:0] sx, sy,
                             input logic [6:0] nx, ny, input logic [8:0] nz);
      write_reg(CFG_INV_CELL_X, ix);
      write_reg(CFG_INV_CELL_Y, iy);
      write_reg(CFG_INV_CELL_Z, iz);
      write_reg(CFG_REGION_START_X, {24'd0, sx});
      write_reg(CFG_REGION_START_Y, {24'd0, sy});
      write_reg(CFG_REGION_SIZE_X, {25'd0, nx});
      write_reg(CFG_REGION_SIZE_Y, {25'd0, ny});
      write_reg(CFG_REGION_SIZE_Z, {23'd0, nz});
   endtask

   function automatic req_type make_req(input logic m, input int px, py, pz, w,
                                        input logic [1:0] ax);
      req_type r;
      r.mode = m;
      r.pos_x = px;
      r.pos_y = py;
      r.pos_z = pz;
      r.weight = w;
      r.diff_axis = ax;
      return r;
   endfunction

   // mostly clustered near the origin so readouts hit painted cells
   function automatic req_type random_req;
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(99) < 80) begin
         r.pos_x = $urandom_range(12 << 16);
         r.pos_y = $urandom_range(12 << 16);
         r.pos_z = $urandom_range(12 << 16) - (2 << 16);
         if ($urandom_range(1)) r.weight = $urandom_range(4 << 16) - (2 << 16);
         if ($urandom_range(2) != 0) r.diff_axis = 2'd0;
      end
      return r;
   endfunction

   task automatic send_random(input int n);
      repeat (n) send_request(random_req());
   endtask

   // corner cases at reset settings
   task automatic test_directed;
      send_request(make_req(1'b0, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000,
                            32'h0001_0000, 2'd0));
      send_request(make_req(1'b1, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 0, 2'd0));
      for (int ax = 1; ax < 4; ax++)
         send_request(make_req(1'b1, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000,
                               0, 2'(ax)));
      send_request(make_req(1'b0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                            32'h0001_0000, 2'd2));
      // saturation of a stored cell, both signs
      repeat (3) send_request(make_req(1'b0, 32'h0005_0000, 32'h0005_0000,
                                       32'h0005_0000, 32'h7fff_ffff, 2'd0));
      send_request(make_req(1'b1, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0, 2'd0));
      repeat (3) send_request(make_req(1'b0, 32'h0006_0000, 32'h0005_0000,
                                       32'h0005_0000, 32'h8000_0000, 2'd0));
      send_request(make_req(1'b1, 32'h0005_8000, 32'h0005_0000, 32'h0005_0000, 0, 2'd0));
      // extremes of position and the periodic wrap
      send_request(make_req(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h0001_0000, 2'd0));
      send_request(make_req(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h0001_0000, 2'd0));
      send_request(make_req(1'b0, 32'h00ff_c000, 32'h00ff_8000, 32'h00ff_0001,
                            32'h0003_0000, 2'd0));
      send_request(make_req(1'b1, 32'hffff_c000, 32'hffff_8000, 32'hffff_0001, 0, 2'd0));
      send_request(make_req(1'b1, 32'h00ff_c000, 32'h0000_0000, 32'h00ff_0001, 0, 2'd3));
      send_request(make_req(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 0, 2'd1));
      drain();
   endtask

   // several register settings, extremes among them
   task automatic test_config_sweep;
      set_region(32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 7'd64, 7'd64, 9'd256);
      send_random(20);
      drain();
      set_region(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'd255, 8'd255,
                 7'd127, 7'd127, 9'd511);
      send_random(25);
      drain();
      set_region(32'h0200_0000, 32'h0080_0000, 32'h0300_0000, 8'd3, 8'd250,
                 7'd0, 7'd5, 9'd0);
      send_random(20);
      drain();
      set_region(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 8'd250, 8'd2,
                 7'd64, 7'd3, 9'd9);
      send_random(25);
      drain();
      set_region($urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
                 7'($urandom), 7'($urandom), 9'($urandom));
      send_random(25);
      drain();
      set_region(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 8'd0, 8'd0,
                 7'd64, 7'd64, 9'd256);
   endtask

   // random traffic under three idle patterns, with a long receiver stall
   task automatic test_random_traffic;
      send_idle_pct = 25;
      rsp_idle_pct  = 64;
      send_random(340);
      drain();
      send_idle_pct = 64;
      rsp_idle_pct  = 25;
      send_random(340);
      drain();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_left = 400;
      send_random(340);
      drain();
   endtask

   // response side: random stalls plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // response check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response value=%0d corners=%0d",
                        rsp_data.value, rsp_data.corners_inside);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.value !== want.value
                || rsp_data.corners_inside !== want.corners_inside) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value=%0d corners=%0d, got value=%0d corners=%0d",
                           want.value, want.corners_inside,
                           rsp_data.value, rsp_data.corners_inside);
            end
         end
      end
   end

   // watchdog on cycles with no handshake (covers the grid clearing pass)
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL cic_mesh_paint_readout");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CFG_INV_CELL_X;
      csr_wdata = '0;
      mismatches = 0;
      quiet_cycles = 0;
      hold_left = 0;
      send_idle_pct = 25;
      rsp_idle_pct = 64;
      inv_size[0] = INV_CELL_RESET;
      inv_size[1] = INV_CELL_RESET;
      inv_size[2] = INV_CELL_RESET;
      start_x = '0;
      start_y = '0;
      size_x = SIZE_XY_RESET;
      size_y = SIZE_XY_RESET;
      size_z = SIZE_Z_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_random_traffic();
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("PASS cic_mesh_paint_readout");
      end else begin
         $display("FAIL cic_mesh_paint_readout");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/cicmpr_pkg.sv
rtl/cic_mesh_paint_readout.sv
tb/testbench.sv
